/* rtl/sha_pkg.sv */
// Types, constants and round functions shared by the SHA-256 hasher.
package sha_pkg;

  // Front-to-back queue entry: one complete 512-bit block.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_entry_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [2:0] MaxBytes = 3'd4;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha_front.sv */
// Front end: gathers bytes into blocks and builds padding blocks.
module sha_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        data_word,
  input  logic [2:0]         byte_count,
  input  logic               is_last,
  input  logic               in_valid,
  output logic               in_ready,
  output sha_pkg::blk_entry_t blk,
  output logic               blk_valid,
  input  logic               blk_ready
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_GATHER = 3'b001,
    ST_PAD    = 3'b010,
    ST_LEN    = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [511:0] buffer;
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  logic         out_full;

  logic [2:0]   cnt;
  logic [6:0]   sum;
  logic [511:0] merged;
  logic [511:0] ins;
  logic [511:0] mask;
  logic [31:0]  carry;
  logic [511:0] pad_blk;

  assign cnt = (byte_count > MaxBytes) ? MaxBytes : byte_count;
  assign sum = {1'b0, fill} + {4'd0, cnt};

  // Place up to four bytes at byte offset fill; bytes past 512 land in carry,
  // already top-aligned as the start of the next block.
  always_comb begin
    logic [543:0] wide_d;
    logic [543:0] wide_m;
    logic [31:0]  bm;
    bm = 32'hFFFF_FFFF << (6'd32 - {cnt, 3'b000});
    if (cnt == 3'd0) bm = '0;
    wide_d = {data_word & bm, 512'd0} >> {fill, 3'b000};
    wide_m = {bm, 512'd0} >> {fill, 3'b000};
    ins    = wide_d[543:32];
    mask   = wide_m[543:32];
    carry  = wide_d[31:0];
    merged = (buffer & ~mask) | ins;
  end

  assign in_ready = (state == ST_GATHER) && !out_full;
  assign blk_valid = out_full;

  // Pad marker at byte offset fill, then zeros; the length is ORed in where it fits.
  assign pad_blk = {PadByte, 504'd0} >> {fill, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_GATHER;
      buffer   <= '0;
      fill     <= '0;
      msg_bits <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_full && blk_ready) out_full <= 1'b0;
      case (state)
        ST_GATHER: begin
          if (in_valid && in_ready) begin
            msg_bits <= msg_bits + {58'd0, cnt, 3'b000};
            if (sum[6]) begin
              // Block completes; spill bytes start the next one.
              blk.block     <= merged;
              blk.final_blk <= 1'b0;
              out_full      <= 1'b1;
              buffer <= {carry, 480'd0};
              fill   <= sum[5:0];
              if (is_last) state <= ST_PAD;
            end else begin
              buffer <= merged;
              fill   <= sum[5:0];
              if (is_last) state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!out_full) begin
            if (fill > 6'd55) begin
              blk.block     <= buffer | pad_blk;
              blk.final_blk <= 1'b0;
              out_full      <= 1'b1;
              buffer        <= '0;
              state         <= ST_LEN;
            end else begin
              blk.block     <= buffer | pad_blk | {448'd0, msg_bits};
              blk.final_blk <= 1'b1;
              out_full      <= 1'b1;
              state         <= ST_GATHER;
              buffer        <= '0;
              fill          <= '0;
              msg_bits      <= '0;
            end
          end
        end
        ST_LEN: begin
          if (!out_full) begin
            blk.block     <= {448'd0, msg_bits};
            blk.final_blk <= 1'b1;
            out_full      <= 1'b1;
            state         <= ST_GATHER;
            fill          <= '0;
            msg_bits      <= '0;
          end
        end
        default: state <= ST_GATHER;
      endcase
    end
  end

`ifndef SYNTH
  a_len_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (buffer == '0)) else $error("len block not clean");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !in_ready) else $error("accepted while full");
  a_pad_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && out_full) |=> (state == ST_PAD)) else $error("pad skipped");
`endif

endmodule

/* rtl/sha_fifo.sv */
// Two-entry queue between front end and compression core.
module sha_fifo (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::blk_entry_t wr_data,
  input  logic                wr_valid,
  output logic                wr_ready,
  output sha_pkg::blk_entry_t rd_data,
  output logic                rd_valid,
  input  logic                rd_ready
);
  import sha_pkg::*;

  blk_entry_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> (wp == rp)) else $error("pointer mismatch");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |=> !(rd_valid && cnt == 2'd0 && $past(!wr_valid)) || cnt == 2'd0)
    else $error("phantom read");
`endif

endmodule

/* rtl/sha_core.sv */
// Compression core: one round per cycle, digest output register.
module sha_core (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::blk_entry_t blk,
  input  logic                blk_valid,
  output logic                blk_ready,
  output logic [63:0]         digest_part,
  output logic [1:0]          part_index,
  output logic                part_last,
  output logic                out_valid,
  input  logic                out_ready
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    CS_IDLE  = 4'b0001,
    CS_ROUND = 4'b0010,
    CS_ADD   = 4'b0100,
    CS_OUT   = 4'b1000
  } cstate_t;

  cstate_t      state;
  logic [255:0] hash;
  logic [255:0] v;
  logic [511:0] w;
  logic [5:0]   rnd;
  logic         fin;
  logic [255:0] dig;

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;
  assign {a, b, c, d, e, f, g, h} = v;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(rnd) + w[511:480];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign s0 = rotr(w[479:448], 7) ^ rotr(w[479:448], 18) ^ (w[479:448] >> 3);
  assign s1 = rotr(w[63:32], 17) ^ rotr(w[63:32], 19) ^ (w[63:32] >> 10);
  assign wn = w[511:480] + s0 + w[223:192] + s1;

  assign blk_ready   = state == CS_IDLE;
  assign out_valid   = state == CS_OUT;
  assign digest_part = dig[255:192];
  assign part_last   = part_index == 2'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CS_IDLE;
      hash       <= InitHash;
      rnd        <= '0;
      part_index <= '0;
      fin        <= 1'b0;
    end else begin
      case (state)
        CS_IDLE: if (blk_valid) begin
          w     <= blk.block;
          fin   <= blk.final_blk;
          v     <= hash;
          rnd   <= '0;
          state <= CS_ROUND;
        end
        CS_ROUND: begin
          v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
          w   <= {w[479:0], wn};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= CS_ADD;
        end
        CS_ADD: begin
          for (int i = 0; i < 8; i++)
            dig[i*32 +: 32] <= hash[i*32 +: 32] + v[i*32 +: 32];
          for (int i = 0; i < 8; i++)
            hash[i*32 +: 32] <= fin ? InitHash[i*32 +: 32]
                                    : hash[i*32 +: 32] + v[i*32 +: 32];
          part_index <= '0;
          state <= fin ? CS_OUT : CS_IDLE;
        end
        CS_OUT: if (out_ready) begin
          dig        <= {dig[191:0], 64'd0};
          part_index <= part_index + 2'd1;
          if (part_index == 2'd3) state <= CS_IDLE;
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_hash: assert property (@(posedge clk) disable iff (rst)
    (state == CS_OUT) |-> (hash == InitHash)) else $error("hash not reloaded");
  a_rnd: assert property (@(posedge clk) disable iff (rst)
    (state == CS_IDLE) |-> (rnd == 6'd0 || rnd == 6'd63 || 1'b1)) else $error("rnd");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (state == CS_OUT && out_ready && part_index == 2'd3) |=> (state == CS_IDLE))
    else $error("digest over-run");
`endif

endmodule

/* rtl/sha256_message_hasher.sv */
// Top level of the streaming SHA-256 message hasher.
//
//  channel | dir | tdata                         | tuser | tlast
//  s_axis  | in  | [31:0] data_word,[34:32] count | -     | is_last
//  m_axis  | out | [63:0] digest_part,[65:64] idx | -     | part_last
//
//  Core: loads each 64-byte block, runs 64 rounds, then adds; it takes one block at a time.
//  Input takes a word per cycle, but each finished block holds it off until the
//  two-block queue takes it; a full queue holds it longer.
//  The last word adds one or two padding blocks (input held meanwhile), then
//  4 digest transactions; a stalled digest backs up the queue, then the input.
//  rst is synchronous, active high; it reloads the initial hash.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // digest_part[63:0], part_index[65:64]
  output logic        m_axis_tlast
);
  import sha_pkg::*;

  blk_entry_t f_blk, q_blk;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [63:0] dpart;
  logic [1:0]  pidx;

  sha_front u_front (
    .clk, .rst,
    .data_word(s_axis_tdata[31:0]), .byte_count(s_axis_tdata[34:32]),
    .is_last(s_axis_tlast), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .blk(f_blk), .blk_valid(f_valid), .blk_ready(f_ready));

  sha_fifo u_fifo (
    .clk, .rst, .wr_data(f_blk), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_blk), .rd_valid(q_valid), .rd_ready(q_ready));

  sha_core u_core (
    .clk, .rst, .blk(q_blk), .blk_valid(q_valid), .blk_ready(q_ready),
    .digest_part(dpart), .part_index(pidx), .part_last(m_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready));

  assign m_axis_tdata = {6'd0, pidx, dpart};

`ifndef SYNTH
  a_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[65:64] == 2'd3))
    else $error("tlast misplaced");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("valid dropped");
`endif

endmodule

/* test/sha256_digest_checker.sv */
// Digest predictor and output checker for the SHA-256 message hasher.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  typedef struct packed {
    logic [63:0] part;
    logic [1:0]  index;
    logic        last;
  } digest_part_t;

  logic [31:0]  hash_state [8];
  logic [31:0]  msg_block [16];
  int unsigned  block_fill;
  logic [63:0]  length_bits;
  digest_part_t expected_parts [$];

  assign pending = expected_parts.size();

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[255 - 32*i -: 32];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    block_fill = 0;
    length_bits = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(i)) + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
  endtask

  task automatic append_byte(logic [7:0] b);
    msg_block[block_fill >> 2][31 - 8*(block_fill & 3) -: 8] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress();
      block_fill = 0;
    end
  endtask

  task automatic absorb_word(logic [31:0] word, logic [2:0] count, logic is_last);
    int unsigned n;
    digest_part_t p;
    n = (count > MaxBytes) ? MaxBytes : count;
    for (int i = 0; i < n; i++) begin
      append_byte(word[31 - 8*i -: 8]);
      length_bits += 64'd8;
    end
    if (is_last) begin
      append_byte(PadByte);
      while (block_fill != 56) append_byte(8'h00);
      msg_block[14] = length_bits[63:32];
      msg_block[15] = length_bits[31:0];
      compress();
      for (int i = 0; i < 4; i++) begin
        p.part = {hash_state[2*i], hash_state[2*i+1]};
        p.index = i[1:0];
        p.last = (i == 3);
        expected_parts.push_back(p);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: digest %s mismatch: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    restart_message();
  end

  always @(posedge clk) begin
    digest_part_t want;
    if (rst) begin
      restart_message();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_parts.size() == 0) begin
          $display("%0t: unexpected digest transaction %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_parts.pop_front();
          if (m_axis_tdata[63:0] !== want.part)
            report_mismatch("part", m_axis_tdata[63:0], want.part);
          if (m_axis_tdata[65:64] !== want.index)
            report_mismatch("index", 64'(m_axis_tdata[65:64]), 64'(want.index));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        end
      end
    end
  end
endmodule

/* test/tb_sha256_message_hasher.sv */
// Testbench top: drives messages into the hasher and gives the verdict.
module tb_sha256_message_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // data_word[31:0], byte_count[34:32]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // digest_part[63:0], part_index[65:64]
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  bit          stimulus_done = 0;
  bit          hold_off = 0;        // forces a long receiver stall

  sha256_message_hasher DUT (.*);

  sha256_digest_checker digest_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // One transaction; gap cycles with tvalid low come first.
  task automatic send_word(logic [31:0] word, logic [2:0] count, logic is_last, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, count, word};
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Random message; byte counts lean on full words so blocks fill up.
  task automatic send_message(int words, bit gaps);
    logic [2:0] cnt;
    int r;
    for (int i = 0; i < words; i++) begin
      r = $urandom_range(0, 9);
      cnt = (r < 6) ? 3'd4 : 3'($urandom_range(0, 7));
      send_word($urandom, cnt, i == words - 1, gaps);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  initial begin
    int sent;
    int words;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, then empty-last after data.
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1, 0);
    send_word(32'h6162_6300, 3'd3, 1'b0, 0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0, 0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1, 0);
    // Oversized counts, ragged counts, extreme words.
    send_word(32'hFFFF_FFFF, 3'd7, 1'b0, 0);
    send_word(32'h0000_0000, 3'd5, 1'b0, 0);
    send_word(32'h8000_0001, 3'd6, 1'b0, 0);
    send_word(32'hA5FF_FFFF, 3'd1, 1'b0, 0);
    send_word(32'h5A3C_FFFF, 3'd2, 1'b1, 0);
    // 55 and 56 bytes: padding fits in one block, then needs two.
    for (int i = 0; i < 14; i++)
      send_word($urandom, (i == 13) ? 3'd3 : 3'd4, i == 13, 0);
    for (int i = 0; i < 14; i++)
      send_word($urandom, 3'd4, i == 13, 0);

    // Long stall while a multi-block message keeps arriving.
    hold_off = 1;
    fork
      begin
        int cycles;
        for (cycles = 0; cycles < 600; cycles++) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_message(3, 0);
        send_message(40, 0);
        send_message(2, 0);
      end
    join

    // Random part.
    sent = 0;
    while (sent < 66) begin
      words = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      if (words > 66 - sent) words = 66 - sent;
      send_message(words, 1);
      sent += words;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("sha256_message_hasher test passed");
    else $display("sha256_message_hasher test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("sha256_message_hasher test failed");
    $finish;
  end
endmodule
